// File: rtl/ple_pkg.sv
// ple_pkg: shared widths, operation and status codes, and types of the
// positional list engine; no dependencies, compiled first
package ple_pkg;

    // field widths of one request and one result
    localparam int OP_W   = 3;
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef logic signed [DATA_W-1:0] t_data;

    // per-cell command for one cycle
    typedef struct packed {
        logic load;     // take the request value
        logic take_lo;  // take the lower neighbor's entry (insert shift)
        logic take_hi;  // take the upper neighbor's entry (delete shift)
        logic cmp;      // capture key compare result
    } t_cell_cmd;

    // one result transaction
    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_data             read_value;
        logic [POS_W-1:0]  found_position;
        logic [LEN_W-1:0]  list_length;
    } t_rsp;

endpackage

// File: rtl/ple_req_if.sv
// ple_req_if: request channel of the positional list engine
// depends on ple_pkg
interface ple_req_if import ple_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;
    t_data            value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

// File: rtl/ple_rsp_if.sv
// ple_rsp_if: result channel of the positional list engine
// depends on ple_pkg
interface ple_rsp_if import ple_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    t_data             read_value;
    logic [POS_W-1:0]  found_position;
    logic [LEN_W-1:0]  list_length;

    modport source (output valid, output status, output read_value,
                    output found_position, output list_length, input ready);
    modport sink   (input valid, input status, input read_value,
                    input found_position, input list_length, output ready);
endinterface

// File: rtl/ple_cell.sv
// ple_cell: one list slot; holds an entry, shifts with its neighbors and
// compares against a key; depends on ple_pkg
module ple_cell import ple_pkg::*; (
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  t_data     i_value,
    input  t_data     i_lo_data,
    input  t_data     i_hi_data,
    output t_data     o_data,
    output logic      o_match
);

    t_data r_data;
    logic  r_match;

    // entry update: load, shift up from below, or shift down from above
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data <= i_value;
        end else if (i_cmd.take_lo) begin
            r_data <= i_lo_data;
        end else if (i_cmd.take_hi) begin
            r_data <= i_hi_data;
        end
    end

    // key compare, held for the search cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_match <= (r_data == i_value);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

// File: rtl/positional_list_engine_core.sv
// positional_list_engine_core: top level, a row of ple_cell slots plus the
// length counter, request decode and result register
// depends on ple_pkg, ple_req_if, ple_rsp_if, ple_cell
//
// Usage:
//   i_req carries one request transaction (op, position, value); o_rsp returns
//   exactly one result transaction (status, read_value, found_position,
//   list_length) per request, in order.
//   Insert, delete, get, clear and unused codes finish in the accept cycle:
//   the result is valid in the cycle after acceptance, and a new request can
//   be taken every cycle while the receiver takes each result. The cells that
//   shift or load do so at that same edge. For locate, the cells register
//   their key compares at the accept edge, then a find-first over the row of
//   match bits fills the result register; i_req.ready is low while it searches.
//   The result register frees up in the cycle the receiver takes it, so a
//   request is accepted while a pending result is handed over.
//   If the receiver stalls, the result is held and i_req.ready stays low
//   until it is taken.
//   Reset holds i_req.ready low, empties the list (length zero) and drops any
//   pending result. Cell contents are not cleared; slots beyond the length
//   are never read.
module positional_list_engine_core import ple_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ple_req_if.sink      i_req,
    ple_rsp_if.source    o_rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic             r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;
    t_rsp             w_search_rsp;

    logic             w_accept;
    logic [CMP_W-1:0] w_pos_x;
    logic [CMP_W-1:0] w_cnt_x;
    logic [CMP_W-1:0] w_p0_x;
    logic [IDX_W-1:0] w_p0;
    logic             w_ins_ok;
    logic             w_del_ok;
    logic             w_rd_pos_ok;
    logic             w_ins_pos_ok;
    logic             w_full;

    t_cell_cmd        w_cmd [DEPTH];
    t_data            w_cell_data [DEPTH];
    logic [DEPTH-1:0] w_match;
    logic [DEPTH-1:0] w_live;
    logic [DEPTH-1:0] w_hits;
    logic [DEPTH-1:0] w_first;
    logic [IDX_W-1:0] w_hit_idx;

    // handshake
    assign i_req.ready = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    // position checks
    assign w_pos_x      = CMP_W'(i_req.position);
    assign w_cnt_x      = CMP_W'(r_count);
    assign w_p0_x       = w_pos_x - CMP_W'(1);
    assign w_p0         = w_p0_x[IDX_W-1:0];
    assign w_full       = (r_count == CNT_W'(DEPTH));
    assign w_ins_pos_ok = (w_pos_x != '0) && (w_pos_x <= w_cnt_x + CMP_W'(1));
    assign w_rd_pos_ok  = (w_pos_x != '0) && (w_pos_x <= w_cnt_x);
    assign w_ins_ok     = w_accept && (i_req.op == OP_INSERT) && w_ins_pos_ok && !w_full;
    assign w_del_ok     = w_accept && (i_req.op == OP_DELETE) && w_rd_pos_ok;

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_data w_lo;
        t_data w_hi;

        if (g == 0) begin : g_lo_edge
            assign w_lo = i_req.value;
        end else begin : g_lo_mid
            assign w_lo = w_cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_hi_edge
            assign w_hi = w_cell_data[g];
        end else begin : g_hi_mid
            assign w_hi = w_cell_data[g+1];
        end

        assign w_cmd[g].load    = w_ins_ok && (CMP_W'(g) == w_p0_x);
        assign w_cmd[g].take_lo = w_ins_ok && (CMP_W'(g) >  w_p0_x);
        assign w_cmd[g].take_hi = w_del_ok && (CMP_W'(g) >= w_p0_x);
        assign w_cmd[g].cmp     = w_accept && (i_req.op == OP_LOCATE);

        ple_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd[g]),
            .i_value   (i_req.value),
            .i_lo_data (w_lo),
            .i_hi_data (w_hi),
            .o_data    (w_cell_data[g]),
            .o_match   (w_match[g])
        );

        assign w_live[g] = (CNT_W'(g) < r_count);
    end

    // request decode: result and next length for all ops but locate
    always_comb begin
        n_count              = r_count;
        n_rsp.status         = STAT_OK;
        n_rsp.read_value     = '0;
        n_rsp.found_position = '0;
        case (i_req.op)
            OP_INSERT: begin
                if (!w_ins_pos_ok) begin
                    n_rsp.status = STAT_BAD_POS;
                end else if (w_full) begin
                    n_rsp.status = STAT_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (!w_rd_pos_ok) begin
                    n_rsp.status = STAT_BAD_POS;
                end else begin
                    n_rsp.read_value = w_cell_data[w_p0];
                    n_count          = r_count - CNT_W'(1);
                end
            end
            OP_GET: begin
                if (!w_rd_pos_ok) begin
                    n_rsp.status = STAT_BAD_POS;
                end else begin
                    n_rsp.read_value = w_cell_data[w_p0];
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        n_rsp.list_length = LEN_W'(n_count);
    end

    // search cycle: first live match
    assign w_hits  = w_match & w_live;
    assign w_first = w_hits & (~w_hits + DEPTH'(1));

    always_comb begin
        w_hit_idx = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if (w_first[j]) begin
                w_hit_idx = w_hit_idx | IDX_W'(j);
            end
        end
    end

    always_comb begin
        w_search_rsp.read_value  = '0;
        w_search_rsp.list_length = LEN_W'(r_count);
        if (w_hits != '0) begin
            w_search_rsp.status         = STAT_OK;
            w_search_rsp.found_position = POS_W'(w_hit_idx) + POS_W'(1);
        end else begin
            w_search_rsp.status         = STAT_NOT_FOUND;
            w_search_rsp.found_position = '0;
        end
    end

    // control state: sequencer, length, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= (w_accept) ? n_count : r_count;
            if (w_accept && (i_req.op == OP_LOCATE)) begin
                r_state <= S_SEARCH;
            end else begin
                r_state <= S_IDLE;
            end
            if ((w_accept && (i_req.op != OP_LOCATE)) || (r_state == S_SEARCH)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_req.op != OP_LOCATE)) begin
            r_rsp <= n_rsp;
        end else if (r_state == S_SEARCH) begin
            r_rsp <= w_search_rsp;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_rsp.status;
    assign o_rsp.read_value     = r_rsp.read_value;
    assign o_rsp.found_position = r_rsp.found_position;
    assign o_rsp.list_length    = r_rsp.list_length;

    // checks
    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted insert did not grow the list by one");

    a_search_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |=> r_out_valid)
        else $error("search cycle did not produce a result");

    a_search_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> !i_req.ready)
        else $error("request taken during search cycle");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.found_position != '0)) |-> (o_rsp.status == STAT_OK))
        else $error("found position reported with error status");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_count <= CNT_W'(DEPTH)))
        else $error("list length beyond depth");

endmodule
